// ===== hw/rtl/kst_pkg.sv =====
// kst_pkg: shared types and constants for the keyed slot table
// field widths of the channels, input kind codes, the decoded operation
// and the command and result records passed between the table's modules
`default_nettype none

package kst_pkg;

  localparam int KIND_W      = 3;
  localparam int KEY_W       = 64;
  localparam int PAYLOAD_W   = 64;
  localparam int COUNT_W     = 5;
  localparam int OVF_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RAISE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOWER  = 3'd4;

  // decoded operation; unknown kinds become a no-op
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP,
    OP_RAISE,
    OP_LOWER,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic                 success;
    logic [PAYLOAD_W-1:0] found_payload;
    logic [COUNT_W-1:0]   count_now;
    logic                 table_full;
    logic                 overflowed;
    logic [OVF_W-1:0]     overflow_now;
    logic                 underflow_error;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kst_in_if.sv =====
// kst_in_if: request channel of the keyed slot table
// valid/ready handshake with kind, key and payload; uses kst_pkg
`default_nettype none

interface kst_in_if import kst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [KEY_W-1:0]     entry_key;
  logic [PAYLOAD_W-1:0] entry_payload;

  modport source (output valid, kind, entry_key, entry_payload, input ready);
  modport sink   (input valid, kind, entry_key, entry_payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kst_out_if.sv =====
// kst_out_if: result channel of the keyed slot table
// valid/ready handshake with status and lookup data; uses kst_pkg
`default_nettype none

interface kst_out_if import kst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 success;
  logic [PAYLOAD_W-1:0] found_payload;
  logic [COUNT_W-1:0]   count_now;
  logic                 table_full;
  logic                 overflowed;
  logic [OVF_W-1:0]     overflow_now;
  logic                 underflow_error;

  modport source (output valid, success, found_payload, count_now, table_full,
                  overflowed, overflow_now, underflow_error, input ready);
  modport sink   (input valid, success, found_payload, count_now, table_full,
                  overflowed, overflow_now, underflow_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kst_front.sv =====
// kst_front: accepts requests, decodes the kind and queues the commands
// depends on kst_pkg and kst_in_if
`default_nettype none

module kst_front import kst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kst_in_if.sink     in_chan,
  output logic       q_valid,
  input  wire logic  q_ready,
  output cmd_t       q_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             push;
  logic             pop;
  op_t              op_dec;

  always_comb begin
    case (in_chan.kind)
      KIND_INSERT: op_dec = OP_INSERT;
      KIND_REMOVE: op_dec = OP_REMOVE;
      KIND_LOOKUP: op_dec = OP_LOOKUP;
      KIND_RAISE:  op_dec = OP_RAISE;
      KIND_LOWER:  op_dec = OP_LOWER;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign in_chan.ready = (fill_r != CNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (fill_r != '0);
  assign pop           = q_valid && q_ready;
  assign q_cmd         = q_mem[rd_ptr_r];

  // pointer wrap at the queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{op: op_dec, key: in_chan.entry_key,
                           payload: in_chan.entry_payload};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kst_back.sv =====
// kst_back: slot table and overflow counter; matches keys, then commits
// depends on kst_pkg and kst_out_if
`default_nettype none

module kst_back import kst_pkg::*; #(
  parameter int SLOTS        = 16,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire cmd_t  q_cmd,
  kst_out_if.source  out_chan
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic {ST_MATCH, ST_EXEC} st_t;

  st_t                     st_r;
  logic [SLOTS-1:0]        valid_r;
  logic [SLOTS-1:0]        valid_nxt;
  logic [KEY_BITS-1:0]     key_r [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [OVF_W-1:0]        ovf_r;
  logic [OVF_W-1:0]        ovf_nxt;

  op_t                     op_r;
  logic [KEY_BITS-1:0]     key_item_r;
  logic [PAYLOAD_BITS-1:0] pay_item_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic                    free_r;
  logic [IDX_W-1:0]        free_idx_r;

  logic [SLOTS-1:0]        hit_vec;
  logic                    hit_any;
  logic [IDX_W-1:0]        hit_idx;
  logic                    free_any;
  logic [IDX_W-1:0]        free_idx;

  logic                    take;
  logic                    out_free;
  logic                    commit;
  logic                    slot_we;
  logic                    out_valid_r;
  res_t                    out_res_r;
  res_t                    res_nxt;

  assign take     = (st_r == ST_MATCH) && q_valid;
  assign q_ready  = (st_r == ST_MATCH);
  assign out_free = !out_valid_r || out_chan.ready;
  assign commit   = (st_r == ST_EXEC) && out_free;

  // parallel key compare with lowest-index priority
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == q_cmd.key[KEY_BITS-1:0]);
    end
    hit_any  = |hit_vec;
    free_any = !(&valid_r);
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    slot_we   = 1'b0;
    res_nxt   = '0;
    if (commit) begin
      case (op_r)
        OP_INSERT: begin
          if (free_r) begin
            valid_nxt[free_idx_r] = 1'b1;
            count_nxt             = count_r + CNT_W'(1);
            slot_we               = 1'b1;
            res_nxt.success       = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (hit_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
            count_nxt            = count_r - CNT_W'(1);
            res_nxt.success      = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (hit_r) begin
            res_nxt.success       = 1'b1;
            res_nxt.found_payload = PAYLOAD_W'(rd_data_r);
          end
        end
        OP_RAISE: begin
          if (ovf_r != '1) begin
            ovf_nxt = ovf_r + OVF_W'(1);
          end
        end
        OP_LOWER: begin
          if (ovf_r == '0) begin
            res_nxt.underflow_error = 1'b1;
          end else begin
            ovf_nxt = ovf_r - OVF_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    res_nxt.count_now    = COUNT_W'(count_nxt);
    res_nxt.table_full   = (count_nxt == CNT_W'(SLOTS));
    res_nxt.overflowed   = (ovf_nxt != '0);
    res_nxt.overflow_now = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_MATCH;
      valid_r     <= '0;
      count_r     <= '0;
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (st_r)
        ST_MATCH: begin
          if (q_valid) begin
            st_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            st_r <= ST_MATCH;
          end
        end
        default: st_r <= ST_MATCH;
      endcase
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r       <= q_cmd.op;
      key_item_r <= q_cmd.key[KEY_BITS-1:0];
      pay_item_r <= q_cmd.payload[PAYLOAD_BITS-1:0];
      hit_r      <= hit_any;
      hit_idx_r  <= hit_idx;
      free_r     <= free_any;
      free_idx_r <= free_idx;
    end
    if (slot_we) begin
      key_r[free_idx_r] <= key_item_r;
    end
  end

  // payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (slot_we) begin
      pay_mem[free_idx_r] <= pay_item_r;
    end
    if (take) begin
      rd_data_r <= pay_mem[hit_idx];
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.success         = out_res_r.success;
  assign out_chan.found_payload   = out_res_r.found_payload;
  assign out_chan.count_now       = out_res_r.count_now;
  assign out_chan.table_full      = out_res_r.table_full;
  assign out_chan.overflowed      = out_res_r.overflowed;
  assign out_chan.overflow_now    = out_res_r.overflow_now;
  assign out_chan.underflow_error = out_res_r.underflow_error;

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_slot_table_core.sv =====
// keyed_slot_table_core: request decoder and queue in front of the slot table
// a request passes the queue, the key compare in the match state and the slot
//   update in the exec state, which loads the result register
// the slot table takes a new request only after its match-then-commit pass ends;
//   the exec state stalls while the result register is still held
// reset: synchronous, clears valid marks, entry count, overflow counter,
//   queue and result valid flag; keys, payloads and result data are not swept
`default_nettype none

module keyed_slot_table_core import kst_pkg::*; #(
  parameter int SLOTS        = 16,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kst_in_if.sink     in_chan,
  kst_out_if.source  out_chan
);

  // decoded commands waiting for the back end
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // front: takes requests while the back end or the result side stalls, until its queue is full
  kst_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  // back: slot table, counters and result register
  kst_back #(
    .SLOTS        (SLOTS),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/kst_checker.sv =====
// kst_checker: port-level checks on the keyed slot table results
// bound to keyed_slot_table_core; depends on kst_pkg
`default_nettype none

module kst_checker import kst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 success,
  input wire logic [PAYLOAD_W-1:0] found_payload,
  input wire logic [COUNT_W-1:0]   count_now,
  input wire logic                 table_full,
  input wire logic [OVF_W-1:0]     overflow_now,
  input wire logic                 underflow_error
);

  logic [OVF_W-1:0] last_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ovf_r <= '0;
    end else if (out_valid && out_ready) begin
      last_ovf_r <= overflow_now;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(overflow_now) &&
      $stable(count_now) && $stable(success))
    else $error("result changed while stalled");

  a_uerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && underflow_error |->
      overflow_now == '0 && !success && found_payload == '0)
    else $error("underflow result inconsistent");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |-> count_now == COUNT_W'(SLOTS))
    else $error("full flag disagrees with count");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |->
      overflow_now == last_ovf_r || overflow_now == last_ovf_r + OVF_W'(1) ||
      overflow_now == last_ovf_r - OVF_W'(1))
    else $error("overflow counter jumped between results");

endmodule

bind keyed_slot_table_core kst_checker #(.SLOTS(SLOTS)) u_kst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .success         (out_chan.success),
  .found_payload   (out_chan.found_payload),
  .count_now       (out_chan.count_now),
  .table_full      (out_chan.table_full),
  .overflow_now    (out_chan.overflow_now),
  .underflow_error (out_chan.underflow_error)
);

`default_nettype wire
